// ===== rtl/crcv_pkg.sv =====
// Shared types and constants for the CRC-16/ARC region verifier.
package crcv_pkg;

  typedef logic [16:0] pos_t;
  typedef logic [15:0] crc_t;

  // result status codes
  localparam logic [1:0] ST_MATCH    = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_UNKNOWN  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_LAYOUT_MODE     = 2'd0;
  localparam logic [1:0] REG_WINDOW_START    = 2'd1;
  localparam logic [1:0] REG_WINDOW_END      = 2'd2;
  localparam logic [1:0] REG_CHECKSUM_OFFSET = 2'd3;

  localparam crc_t CRC_POLY = 16'hA001;
  localparam crc_t CRC_INIT = 16'h0000;

  // fixed layouts
  localparam pos_t SMALL_SIZE  = 17'h08000;
  localparam pos_t SMALL_START = 17'h00030;
  localparam pos_t SMALL_END   = 17'h07FEA;
  localparam pos_t SMALL_OFF   = 17'h07FEA;
  localparam pos_t LARGE_SIZE  = 17'h10000;
  localparam pos_t LARGE_START = 17'h08041;
  localparam pos_t LARGE_END   = 17'h0FFFA;
  localparam pos_t LARGE_OFF   = 17'h0FFFA;

endpackage

// ===== rtl/crc16_arc_region_verifier_core.sv =====
// CRC-16/ARC region verifier: byte stream in, one status result per image.
//
//  channel | ports                                         | direction | transfer when
//  --------+-----------------------------------------------+-----------+------------------
//  in      | in_valid in_stall in_data_byte in_last_byte   | to block  | valid & !stall
//  out     | out_valid out_stall out_status out_*_crc      | from block| valid & !stall
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data        | to block  | valid & ready
//
// One byte per cycle. Each byte updates three CRC-16 registers (explicit window and both
// fixed layouts) through one byte-wide CRC step; the last byte's status is formed in the
// same cycle and lands in the output register, so the result appears in the cycle after the
// last byte's transfer. Synchronous active-low reset clears the config and the counters.
// A stalled output only holds back a last byte; other bytes keep flowing.
module crc16_arc_region_verifier_core #(
  parameter int MAX_IMAGE_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_computed_crc,
  output logic [15:0] out_stored_crc,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam crcv_pkg::pos_t MaxPos = 17'(MAX_IMAGE_BYTES);

  function automatic crcv_pkg::crc_t crc_step(input crcv_pkg::crc_t crc,
                                              input logic [7:0] b);
    crcv_pkg::crc_t c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ crcv_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic crcv_pkg::crc_t crc_track(input crcv_pkg::pos_t pos,
                                               input logic [7:0] b,
                                               input crcv_pkg::pos_t start,
                                               input crcv_pkg::pos_t stop,
                                               input crcv_pkg::crc_t crc);
    return (pos >= start && pos < stop) ? crc_step(crc, b) : crc;
  endfunction

  // big-endian capture: high byte at off, low byte at off + 1
  function automatic crcv_pkg::crc_t word_track(input crcv_pkg::pos_t pos,
                                                input logic [7:0] b,
                                                input crcv_pkg::pos_t off,
                                                input crcv_pkg::crc_t word);
    crcv_pkg::crc_t w;
    w = word;
    if (pos == off) w[15:8] = b;
    if (pos == off + 17'd1) w[7:0] = b;
    return w;
  endfunction

  // configuration
  logic                 mode_r;
  crcv_pkg::pos_t       win_start_r, win_end_r;
  logic [15:0]          cks_off_r;

  // per-image state
  crcv_pkg::pos_t       pos_r, pos_nxt;
  crcv_pkg::crc_t       crc_exp_r, crc_sml_r, crc_lrg_r;
  crcv_pkg::crc_t       crc_exp_nxt, crc_sml_nxt, crc_lrg_nxt;
  crcv_pkg::crc_t       sto_exp_r, sto_sml_r, sto_lrg_r;
  crcv_pkg::crc_t       sto_exp_nxt, sto_sml_nxt, sto_lrg_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           status_r, status_nxt;
  crcv_pkg::crc_t       comp_r, comp_nxt, stor_r, stor_nxt;

  logic                 in_xfer, too_long;
  crcv_pkg::pos_t       img_len, sel_start, sel_end, sel_off;
  crcv_pkg::crc_t       sel_crc, sel_sto;
  logic                 known;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall && in_last_byte;
  assign in_xfer   = in_valid && !in_stall;
  assign too_long  = pos_r >= MaxPos;
  assign img_len   = pos_r + 17'd1;

  always_comb begin
    crc_exp_nxt = crc_track(pos_r, in_data_byte, win_start_r, win_end_r, crc_exp_r);
    crc_sml_nxt = crc_track(pos_r, in_data_byte, crcv_pkg::SMALL_START,
                            crcv_pkg::SMALL_END, crc_sml_r);
    crc_lrg_nxt = crc_track(pos_r, in_data_byte, crcv_pkg::LARGE_START,
                            crcv_pkg::LARGE_END, crc_lrg_r);
    sto_exp_nxt = word_track(pos_r, in_data_byte, {1'b0, cks_off_r}, sto_exp_r);
    sto_sml_nxt = word_track(pos_r, in_data_byte, crcv_pkg::SMALL_OFF, sto_sml_r);
    sto_lrg_nxt = word_track(pos_r, in_data_byte, crcv_pkg::LARGE_OFF, sto_lrg_r);
    pos_nxt     = pos_r + 17'd1;
  end

  // final check, on the values that include the last byte
  always_comb begin
    known     = 1'b1;
    sel_start = win_start_r;
    sel_end   = win_end_r;
    sel_off   = {1'b0, cks_off_r};
    sel_crc   = crc_exp_nxt;
    sel_sto   = sto_exp_nxt;
    if (mode_r) begin
      if (img_len == crcv_pkg::SMALL_SIZE) begin
        sel_start = crcv_pkg::SMALL_START;
        sel_end   = crcv_pkg::SMALL_END;
        sel_off   = crcv_pkg::SMALL_OFF;
        sel_crc   = crc_sml_nxt;
        sel_sto   = sto_sml_nxt;
      end else if (img_len == crcv_pkg::LARGE_SIZE) begin
        sel_start = crcv_pkg::LARGE_START;
        sel_end   = crcv_pkg::LARGE_END;
        sel_off   = crcv_pkg::LARGE_OFF;
        sel_crc   = crc_lrg_nxt;
        sel_sto   = sto_lrg_nxt;
      end else begin
        known = 1'b0;
      end
    end
    status_nxt = crcv_pkg::ST_INVALID;
    comp_nxt   = '0;
    stor_nxt   = '0;
    if (!too_long) begin
      if (!known) begin
        status_nxt = crcv_pkg::ST_UNKNOWN;
      end else if (sel_end > img_len || sel_start > sel_end ||
                   sel_off + 17'd1 >= img_len) begin
        status_nxt = crcv_pkg::ST_INVALID;
      end else begin
        comp_nxt   = sel_crc;
        stor_nxt   = sel_sto;
        status_nxt = (sel_crc == sel_sto) ? crcv_pkg::ST_MATCH : crcv_pkg::ST_MISMATCH;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (in_xfer && in_last_byte) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      win_start_r <= '0;
      win_end_r   <= '0;
      cks_off_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        crcv_pkg::REG_LAYOUT_MODE:     mode_r      <= cfg_data[0];
        crcv_pkg::REG_WINDOW_START:    win_start_r <= cfg_data;
        crcv_pkg::REG_WINDOW_END:      win_end_r   <= cfg_data;
        crcv_pkg::REG_CHECKSUM_OFFSET: cks_off_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_xfer && in_last_byte)) begin
      pos_r     <= '0;
      crc_exp_r <= crcv_pkg::CRC_INIT;
      crc_sml_r <= crcv_pkg::CRC_INIT;
      crc_lrg_r <= crcv_pkg::CRC_INIT;
      sto_exp_r <= '0;
      sto_sml_r <= '0;
      sto_lrg_r <= '0;
    end else if (in_xfer && !too_long) begin
      pos_r     <= pos_nxt;
      crc_exp_r <= crc_exp_nxt;
      crc_sml_r <= crc_sml_nxt;
      crc_lrg_r <= crc_lrg_nxt;
      sto_exp_r <= sto_exp_nxt;
      sto_sml_r <= sto_sml_nxt;
      sto_lrg_r <= sto_lrg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_last_byte) begin
      status_r <= status_nxt;
      comp_r   <= comp_nxt;
      stor_r   <= stor_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_computed_crc = comp_r;
  assign out_stored_crc   = stor_r;

endmodule

// ===== rtl/crcv_checker.sv =====
// Port-level checker for the CRC-16/ARC region verifier, bound to the top level.
module crcv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [15:0] out_computed_crc,
  input logic [15:0] out_stored_crc
);

  // invalid or unknown results carry zero words
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == crcv_pkg::ST_INVALID || out_status == crcv_pkg::ST_UNKNOWN)
    |-> out_computed_crc == 16'h0000 && out_stored_crc == 16'h0000)
    else $error("nonzero crc on invalid or unknown status");

  // match/mismatch agrees with the reported words
  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == crcv_pkg::ST_MATCH || out_status == crcv_pkg::ST_MISMATCH)
    |-> (out_status == crcv_pkg::ST_MATCH) == (out_computed_crc == out_stored_crc))
    else $error("status disagrees with crc compare");

  // a last-byte transfer yields a result next cycle
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_byte |=> out_valid)
    else $error("no result after last byte");

  // other bytes produce no result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && !in_stall && in_last_byte) && !(out_valid && out_stall) |=> !out_valid)
    else $error("result without last byte");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
    $stable(out_computed_crc) && $stable(out_stored_crc))
    else $error("stalled result changed");

endmodule

bind crc16_arc_region_verifier_core crcv_checker u_crcv_checker (.*);

// ===== dv/crc16_arc_region_checker.sv =====
// Verdict checker for the CRC-16/ARC region verifier: watches all channels, predicts, compares.
module crc16_arc_region_checker #(
  parameter int MAX_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [15:0] out_computed_crc,
  input  logic [15:0] out_stored_crc,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  typedef struct packed {
    logic [1:0]     status;
    crcv_pkg::crc_t computed;
    crcv_pkg::crc_t stored;
  } verdict_t;

  // running CRC and captured word of one window/offset layout
  typedef struct packed {
    crcv_pkg::crc_t crc;
    crcv_pkg::crc_t word;
  } region_t;

  verdict_t verdict_q[$];

  logic    mode_q;
  int      win_start;
  int      win_end;
  int      chk_off;
  int      byte_pos;
  region_t rg_expl;
  region_t rg_small;
  region_t rg_large;
  int      fails;
  int      seen;

  function automatic crcv_pkg::crc_t arc_update(crcv_pkg::crc_t c, logic [7:0] b);
    crcv_pkg::crc_t r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ crcv_pkg::CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic region_t region_absorb(region_t r, int pos, logic [7:0] b,
                                            int s, int e, int o);
    region_t n;
    n = r;
    if (pos >= s && pos < e) n.crc = arc_update(n.crc, b);
    if (pos == o) n.word[15:8] = b;
    if (pos == o + 1) n.word[7:0] = b;
    return n;
  endfunction

  function automatic verdict_t close_image(int len);
    verdict_t v;
    int       s;
    int       e;
    int       o;
    region_t  r;
    logic     known;
    v.status = crcv_pkg::ST_INVALID;
    v.computed = '0;
    v.stored = '0;
    known = 1'b1;
    s = 0;
    e = 0;
    o = 0;
    r = '0;
    if (mode_q == 1'b0) begin
      s = win_start; e = win_end; o = chk_off; r = rg_expl;
    end else if (len == int'(crcv_pkg::SMALL_SIZE)) begin
      s = int'(crcv_pkg::SMALL_START);
      e = int'(crcv_pkg::SMALL_END);
      o = int'(crcv_pkg::SMALL_OFF);
      r = rg_small;
    end else if (len == int'(crcv_pkg::LARGE_SIZE)) begin
      s = int'(crcv_pkg::LARGE_START);
      e = int'(crcv_pkg::LARGE_END);
      o = int'(crcv_pkg::LARGE_OFF);
      r = rg_large;
    end else begin
      known = 1'b0;
    end
    if (!known) begin
      v.status = crcv_pkg::ST_UNKNOWN;
    end else if (e > len || s > e || o + 1 >= len) begin
      v.status = crcv_pkg::ST_INVALID;
    end else begin
      v.computed = r.crc;
      v.stored = r.word;
      v.status = (r.crc == r.word) ? crcv_pkg::ST_MATCH : crcv_pkg::ST_MISMATCH;
    end
    return v;
  endfunction

  task automatic report_mismatch(string what, verdict_t want, verdict_t got);
    fails++;
    if (fails <= 10) begin
      $display("%s: status exp %0d got %0d, computed exp %04h got %04h, stored exp %04h got %04h",
               what, want.status, got.status, want.computed, got.computed,
               want.stored, got.stored);
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    verdict_t got;
    logic     too_long;
    if (!rst_n) begin
      verdict_q.delete();
      mode_q = 1'b0;
      win_start = 0;
      win_end = 0;
      chk_off = 0;
      byte_pos = 0;
      rg_expl = '0;
      rg_small = '0;
      rg_large = '0;
      fails = 0;
      seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          crcv_pkg::REG_LAYOUT_MODE:     mode_q = cfg_data[0];
          crcv_pkg::REG_WINDOW_START:    win_start = int'(cfg_data);
          crcv_pkg::REG_WINDOW_END:      win_end = int'(cfg_data);
          crcv_pkg::REG_CHECKSUM_OFFSET: chk_off = int'(cfg_data[15:0]);
          default: ;
        endcase
      end

      // result transfer first: a verdict always trails its last byte
      if (out_valid && !out_stall) begin
        got.status = out_status;
        got.computed = out_computed_crc;
        got.stored = out_stored_crc;
        if (verdict_q.size() == 0) begin
          want = '0;
          report_mismatch("unexpected verdict", want, got);
        end else begin
          want = verdict_q.pop_front();
          seen++;
          if (want !== got) report_mismatch("verdict mismatch", want, got);
        end
      end

      if (in_valid && !in_stall) begin
        too_long = (byte_pos >= MAX_BYTES);
        if (!too_long) begin
          rg_expl = region_absorb(rg_expl, byte_pos, in_data_byte, win_start, win_end, chk_off);
          rg_small = region_absorb(rg_small, byte_pos, in_data_byte,
                                   int'(crcv_pkg::SMALL_START), int'(crcv_pkg::SMALL_END),
                                   int'(crcv_pkg::SMALL_OFF));
          rg_large = region_absorb(rg_large, byte_pos, in_data_byte,
                                   int'(crcv_pkg::LARGE_START), int'(crcv_pkg::LARGE_END),
                                   int'(crcv_pkg::LARGE_OFF));
        end
        if (in_last_byte) begin
          if (too_long) begin
            want.status = crcv_pkg::ST_INVALID;
            want.computed = '0;
            want.stored = '0;
          end else begin
            want = close_image(byte_pos + 1);
          end
          verdict_q.push_back(want);
          byte_pos = 0;
          rg_expl = '0;
          rg_small = '0;
          rg_large = '0;
        end else if (!too_long) begin
          byte_pos++;
        end
      end
    end
    pending <= verdict_q.size();
    fail_count <= fails;
    checked <= seen;
  end

endmodule

// ===== dv/tb_crc16_arc_region_verifier_core.sv =====
// Testbench top for the CRC-16/ARC region verifier: image stimulus, output stalls, verdict.
module tb_crc16_arc_region_verifier_core;

  localparam int     MAX_BYTES    = 65536;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     RANDOM_ITEMS = 650;
  localparam longint CYCLE_LIMIT  = 6000000;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY} rx_pattern_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [15:0] out_computed_crc;
  logic [15:0] out_stored_crc;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  int fail_count;
  int pending;
  int checked;

  logic [7:0] img [0:MAX_BYTES+15];

  int     burst_left = 0;
  bit     quiet_sender = 1'b0;
  bit     offering = 1'b0;
  bit     hold_req = 1'b0;
  int     images_sent = 0;
  int     bytes_sent = 0;
  int     reg_writes = 0;
  longint cycles = 0;

  always #6 clk = ~clk;

  crc16_arc_region_verifier_core #(
    .MAX_IMAGE_BYTES(MAX_BYTES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_computed_crc (out_computed_crc),
    .out_stored_crc   (out_stored_crc),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  crc16_arc_region_checker #(
    .MAX_BYTES(MAX_BYTES)
  ) u_verdict_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_computed_crc (out_computed_crc),
    .out_stored_crc   (out_stored_crc),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked          (checked)
  );

  // used only to build images whose stored word matches
  function automatic logic [15:0] arc_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ crcv_pkg::CRC_POLY) : (r >> 1);
    return r;
  endfunction

  task automatic fill_random(int len);
    for (int i = 0; i < len; i++) img[i] = $urandom_range(0, 255);
  endtask

  task automatic place_crc(int s, int e, int o);
    logic [15:0] c;
    c = crcv_pkg::CRC_INIT;
    for (int i = s; i < e; i++) c = arc_byte(c, img[i]);
    img[o] = c[15:8];
    img[o+1] = c[7:0];
  endtask

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = quiet_sender ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        if (offering) in_valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    offering = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_image(int len);
    quiet_sender = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) send_byte(img[i], i == len - 1);
    images_sent++;
    bytes_sent += len;
  endtask

  // stop offering and wait for every predicted verdict, plus a short tail
  task automatic drain();
    if (offering) in_valid <= 1'b0;
    offering = 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
  endtask

  task automatic configure(logic mode, int s, int e, int o);
    logic [16:0] d;
    d = $urandom;
    d[0] = mode;
    write_reg(crcv_pkg::REG_LAYOUT_MODE, d);
    write_reg(crcv_pkg::REG_WINDOW_START, s[16:0]);
    write_reg(crcv_pkg::REG_WINDOW_END, e[16:0]);
    d = $urandom;
    d[15:0] = o[15:0];
    write_reg(crcv_pkg::REG_CHECKSUM_OFFSET, d);
    cfg_valid <= 1'b0;
  endtask

  initial begin : receiver
    rx_pattern_t pattern;
    int          pattern_left;
    pattern = RX_OPEN;
    pattern_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // long hold-off so the output register fills and the input backs up
        out_stall <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern = rx_pattern_t'($urandom_range(0, 2));
          pattern_left = $urandom_range(20, 200);
        end
        pattern_left--;
        case (pattern)
          RX_OPEN:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          default:  out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_crc16_arc_region_verifier_core: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic mode;
    int   len;
    int   s;
    int   e;
    int   o;
    int   min_len;
    int   n_img;
    int   pick;
    int   random_items;
    int   phase;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: offset word runs past a one-byte image
    img[0] = 8'hFF;
    send_image(1);
    // empty window, zero stored word
    img[0] = 8'h00;
    img[1] = 8'h00;
    send_image(2);
    drain();

    configure(1'b0, 0, 2, 2);
    img[0] = 8'h00;
    img[1] = 8'hFF;
    place_crc(0, 2, 2);
    send_image(4);
    img[3] = img[3] ^ 8'h01;
    send_image(4);
    drain();

    // window end past the image
    configure(1'b0, 0, 5, 2);
    fill_random(4);
    send_image(4);
    drain();
    // start beyond end
    configure(1'b0, 3, 2, 1);
    fill_random(4);
    send_image(4);
    drain();
    // stored word's low byte past the image
    configure(1'b0, 0, 2, 3);
    fill_random(4);
    send_image(4);
    drain();
    configure(1'b0, MAX_BYTES, MAX_BYTES, MAX_BYTES - 1);
    fill_random(2);
    send_image(2);
    drain();
    // preset mode, length matches no layout
    configure(1'b1, 0, 0, 0);
    fill_random(2);
    send_image(2);
    drain();

    // full-length preset layouts
    fill_random(int'(crcv_pkg::SMALL_SIZE));
    place_crc(int'(crcv_pkg::SMALL_START), int'(crcv_pkg::SMALL_END),
              int'(crcv_pkg::SMALL_OFF));
    send_image(int'(crcv_pkg::SMALL_SIZE));
    img[int'(crcv_pkg::SMALL_OFF) + 1] = img[int'(crcv_pkg::SMALL_OFF) + 1] ^ 8'h5A;
    send_image(int'(crcv_pkg::SMALL_SIZE));
    fill_random(int'(crcv_pkg::LARGE_SIZE));
    place_crc(int'(crcv_pkg::LARGE_START), int'(crcv_pkg::LARGE_END),
              int'(crcv_pkg::LARGE_OFF));
    send_image(int'(crcv_pkg::LARGE_SIZE));
    drain();
    // over-length image: counter saturates, verdict is invalid
    configure(1'b0, 0, MAX_BYTES, 0);
    fill_random(MAX_BYTES + 4);
    send_image(MAX_BYTES + 4);
    drain();

    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      mode = 1'b0;
      if (pick < 7) begin
        // legal explicit layout, stored word outside the window
        e = $urandom_range(0, 24);
        s = $urandom_range(0, e);
        if (s >= 2 && $urandom_range(0, 1) == 1) o = $urandom_range(0, s - 2);
        else o = $urandom_range(e, e + 8);
        min_len = (e > o + 2) ? e : o + 2;
      end else if (pick == 7) begin
        s = $urandom_range(0, 131071);
        e = $urandom_range(0, 131071);
        o = $urandom_range(0, 65535);
        min_len = 1;
      end else begin
        mode = (pick == 8);
        s = $urandom_range(0, 30);
        e = $urandom_range(0, 30);
        o = $urandom_range(0, 30);
        min_len = 1;
      end
      configure(mode, s, e, o);
      n_img = $urandom_range(1, 6);
      // two rounds can never reach the item budget, so this round always runs
      if (phase == 2) hold_req = 1'b1;
      for (int k = 0; k < n_img || hold_req; k++) begin
        if ($urandom_range(0, 99) < 85) len = min_len + $urandom_range(0, 8);
        else len = $urandom_range(1, min_len + 1);
        fill_random(len);
        if (pick < 7 && len >= min_len && $urandom_range(0, 9) < 6) place_crc(s, e, o);
        send_image(len);
        random_items += len;
      end
      drain();
      phase++;
    end

    drain();
    repeat (8) @(posedge clk);
    $display("summary: %0d images, %0d bytes, %0d register writes, %0d verdicts compared",
             images_sent, bytes_sent, reg_writes, checked);
    $display("summary: explicit windows, both preset layouts at full size, over-length image");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_crc16_arc_region_verifier_core: PASS");
    end else begin
      $display("tb_crc16_arc_region_verifier_core: FAIL");
    end
    $finish;
  end

endmodule
